// File: sv/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// File: sv/bffa_pkg.sv
// types, constants and bit helpers for the first-fit bitmap allocator
// no dependencies
package bffa_pkg;

   localparam int MAP_BYTES_DEF = 512;

   localparam logic [8:0] INODE_START_RST = 9'd0;
   localparam logic [8:0] DATA_START_RST  = 9'd4;
   localparam logic [7:0] FULL_BYTE       = 8'hff;

   localparam logic REG_INODE_START = 1'b0;
   localparam logic REG_DATA_START  = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_ALLOC = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [11:0] bit_index;
      logic        found;
      logic [7:0]  read_value;
   } rsp_type;

   // offset of first clear bit, msb is offset 0
   function automatic logic [2:0] first_clear_off(input logic [7:0] b);
      logic [2:0] off;
      off = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!b[7 - k]) begin
            off = 3'(k);
         end
      end
      return off;
   endfunction

   function automatic logic [7:0] set_first_clear(input logic [7:0] b);
      logic [2:0] off;
      off = first_clear_off(b);
      return b | (8'h80 >> off);
   endfunction

endpackage

// File: sv/bffa_ram.sv
// single write, single read bitmap memory with registered read data
// uses no package items
module bffa_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/bffa_seq.sv
// sequencer: clearing pass, byte read/write and first-fit scan over the bitmap
// depends on bffa_pkg
module bffa_seq #(
   parameter int MAP_BYTES = 512,
   parameter int AW        = $clog2(MAP_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bffa_pkg::op_type  op,
   input  logic              region,
   input  logic [8:0]        byte_index,
   input  logic [7:0]        byte_value,
   input  logic [8:0]        inode_start,
   input  logic [8:0]        data_start,
   output logic              ram_we,
   output logic [AW-1:0]     ram_waddr,
   output logic [7:0]        ram_wdata,
   output logic              ram_re,
   output logic [AW-1:0]     ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              done_vld,
   input  logic              done_ack,
   output bffa_pkg::rsp_type res
);
   import bffa_pkg::*;

   localparam int IW = (AW >= 9) ? AW + 1 : 10;
   localparam logic [IW-1:0] MAP_END  = IW'(MAP_BYTES);
   localparam logic [IW-1:0] MAP_LAST = IW'(MAP_BYTES - 1);

   seq_state_type state_ff, state_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [IW-1:0] pend_addr_ff, pend_addr_in;
   rsp_type       res_ff, res_in;

   logic          req_in_range;
   logic [IW-1:0] start_ptr;
   logic          ptr_lt;
   logic          scan_hit;

   assign req_in_range = IW'(byte_index) < MAP_END;
   assign start_ptr    = region ? IW'(data_start) : IW'(inode_start);
   assign ptr_lt       = ptr_ff < MAP_END;
   assign scan_hit     = pend_vld_ff && (ram_rdata != FULL_BYTE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == MAP_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op)
                  OP_READ:  state_in = req_in_range ? ST_READ : ST_DONE;
                  OP_ALLOC: state_in = ST_SCAN;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (scan_hit || (!pend_vld_ff && !ptr_lt)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ptr_in       = ptr_ff;
      pend_vld_in  = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_in       = res_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ptr_in = ptr_ff + IW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               ptr_in = start_ptr;
               res_in = '0;
            end
         end
         ST_READ: begin
            res_in.read_value = ram_rdata;
         end
         ST_SCAN: begin
            if (scan_hit) begin
               res_in.found     = 1'b1;
               res_in.bit_index = {pend_addr_ff[8:0], first_clear_off(ram_rdata)};
            end else if (ptr_lt) begin
               ptr_in       = ptr_ff + IW'(1);
               pend_vld_in  = 1'b1;
               pend_addr_in = ptr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff[AW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_IDLE: begin
            ram_waddr = AW'(byte_index);
            ram_wdata = byte_value;
            ram_raddr = AW'(byte_index);
            if (req_valid && req_in_range) begin
               ram_we = (op == OP_WRITE);
               ram_re = (op == OP_READ);
            end
         end
         ST_SCAN: begin
            ram_waddr = pend_addr_ff[AW-1:0];
            ram_wdata = set_first_clear(ram_rdata);
            ram_we    = scan_hit;
            ram_re    = !scan_hit && ptr_lt;
         end
         default: begin
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign done_vld  = (state_ff == ST_DONE);
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ptr_ff      <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

endmodule

// File: sv/bitmap_first_fit_allocator_top.sv
// First-fit bitmap allocator. After reset the bitmap memory is swept to zero,
// one byte per cycle, and no word is accepted until the sweep is done
// (config writes are taken throughout). One word is worked on at a time. An
// allocate reads the bitmap one byte per cycle through the single memory
// read port starting at the region's start byte, until it finds a byte with
// a clear bit or runs past the end of the map. A finished result waits in
// the output register while the next word is taken.
// depends on bffa_pkg, bffa_seq, bffa_ram and assert_macros.svh
`include "assert_macros.svh"

module bitmap_first_fit_allocator_top #(
   parameter int MAP_BYTES = bffa_pkg::MAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_index[8:0], byte_value[16:9], zero pad
   input  logic [2:0]  req_tuser,   // operation[1:0], region[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // bit_index[11:0], read_value[19:12], zero pad
   output logic        rsp_tuser,   // found
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bffa_pkg::*;

   localparam int AW = $clog2(MAP_BYTES);

   logic [8:0] inode_start_ff, inode_start_in;
   logic [8:0] data_start_ff, data_start_in;
   logic       csr_wr;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic    done_vld, done_ack;
   rsp_type seq_res;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      inode_start_in = inode_start_ff;
      data_start_in  = data_start_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_INODE_START) begin
            inode_start_in = csr_pwdata[8:0];
         end else begin
            data_start_in = csr_pwdata[8:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DATA_START) ? {23'd0, data_start_ff}
                                                          : {23'd0, inode_start_ff};

   bffa_seq #(
      .MAP_BYTES (MAP_BYTES),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .op          (op_type'(req_tuser[1:0])),
      .region      (req_tuser[2]),
      .byte_index  (req_tdata[8:0]),
      .byte_value  (req_tdata[16:9]),
      .inode_start (inode_start_ff),
      .data_start  (data_start_ff),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .done_vld    (done_vld),
      .done_ack    (done_ack),
      .res         (seq_res)
   );

   bffa_ram #(
      .DEPTH (MAP_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // output register
   assign done_ack = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      if (done_vld && done_ack) begin
         rsp_in     = seq_res;
         rsp_vld_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.read_value, rsp_ff.bit_index};
   assign rsp_tuser  = rsp_ff.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_start_ff <= INODE_START_RST;
         data_start_ff  <= DATA_START_RST;
         rsp_vld_ff     <= 1'b0;
      end else begin
         inode_start_ff <= inode_start_in;
         data_start_ff  <= data_start_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `ASSERT_NEXT(a_one_word_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLY(a_found_has_no_read, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[19:12] == 8'd0)
   `ASSERT_IMPLY(a_miss_has_no_index, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[11:0] == 12'd0)

endmodule
